FILE: rtl/core/scs_pkg.sv
`timescale 1ns / 1ps
package scs_pkg;
  localparam int unsigned SLOTS_DEF = 64;
  localparam int unsigned SLOT_W    = 6;
  localparam int unsigned SEC_W     = 32;
  localparam int unsigned PIN_W     = 8;
  localparam int unsigned FUNC_W    = 2;

  localparam logic [PIN_W-1:0] PIN_MAX = '1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ACQUIRE = 2'd0,
    FUNC_RELEASE = 2'd1,
    FUNC_FLUSH   = 2'd2,
    FUNC_NONE    = 2'd3
  } func_e;

  // one result record
  typedef struct packed {
    logic [SLOT_W-1:0] slot_index;
    logic              hit;
    logic              write_back;
    logic [SEC_W-1:0]  write_back_sector;
    logic              fill;
    logic              all_pinned;
    logic              last;
  } rsp_t;
endpackage

FILE: rtl/core/scs_if.sv
`timescale 1ns / 1ps
interface scs_req_if;
  logic                        valid;
  logic                        ready;
  logic [scs_pkg::FUNC_W-1:0]  func;
  logic [scs_pkg::SEC_W-1:0]   sector;
  logic [scs_pkg::SLOT_W-1:0]  slot;
  logic                        set_dirty;
  modport source (output valid, func, sector, slot, set_dirty, input ready);
  modport sink   (input valid, func, sector, slot, set_dirty, output ready);
endinterface

interface scs_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [scs_pkg::SLOT_W-1:0]  slot_index;
  logic                        hit;
  logic                        write_back;
  logic [scs_pkg::SEC_W-1:0]   write_back_sector;
  logic                        fill;
  logic                        all_pinned;
  logic                        last;
  modport source (output valid, slot_index, hit, write_back, write_back_sector, fill,
                  all_pinned, last, input ready);
  modport sink   (input valid, slot_index, hit, write_back, write_back_sector, fill,
                  all_pinned, last, output ready);
endinterface

FILE: rtl/core/scs_ram.sv
`timescale 1ns / 1ps
module scs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: rtl/core/pinned_sector_cache_tags.sv
`timescale 1ns / 1ps
// An acquire scans the tags serially through the entry RAM and stops at a hit; a miss
//   scans every slot, and an eviction reads the victim's old sector back from the RAM;
//   a flush reads and returns each written-back entry in turn.
// Release and a flush with nothing dirty return no result.
// One item at a time: a new request is taken only in idle, after the last item ends.
// Reset: valid, dirty and pinned flags clear at once; entry RAM is not cleared.
module pinned_sector_cache_tags #(
  parameter int unsigned SLOTS = scs_pkg::SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  scs_req_if.sink     req_i,
  scs_rsp_if.source   rsp_o
);
  import scs_pkg::*;

  localparam int unsigned IW    = $clog2(SLOTS);
  localparam int unsigned RAM_W = PIN_W + SEC_W;

  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_MISS, S_VICT, S_REL, S_FFIND, S_FDATA, S_OUT
  } state_e;

  state_e state_q;

  // per-slot flags in flops; pin counts and sectors in the entry RAM
  logic [SLOTS-1:0] valid_q, dirty_q, pinned_q;

  logic [SEC_W-1:0] sector_q;
  logic [8:0]       mod_sum_d, mod_sum_q;
  logic [8:0]       mod_red;
  logic [IW-1:0]    mod_r_q;
  logic [IW-1:0]    addr_q, rd_idx_q, idx_q;
  logic             issue_q, rd_vld_q, flush_q, dirty_in_q;
  rsp_t             rsp_q;

  logic             ram_we;
  logic [IW-1:0]    ram_wa, ram_ra;
  logic [RAM_W-1:0] ram_wd, ram_rd;

  logic [PIN_W-1:0] rd_pin;
  logic [SEC_W-1:0] rd_sec;
  assign rd_pin = pinned_q[rd_idx_q] ? ram_rd[RAM_W-1 -: PIN_W] : '0;
  assign rd_sec = ram_rd[SEC_W-1:0];

  // tag compare on the entry just read
  logic look_hit, look_end;
  assign look_hit = rd_vld_q && valid_q[rd_idx_q] && (rd_sec == sector_q);
  assign look_end = rd_vld_q && (rd_idx_q == IW'(SLOTS - 1));

  // lowest invalid slot
  logic          inv_found;
  logic [IW-1:0] inv_idx;
  always_comb begin
    inv_found = 1'b0;
    inv_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        inv_found = 1'b1;
        inv_idx   = IW'(i);
      end
    end
  end

  // first unpinned slot probing upward from sector mod SLOTS
  logic          vic_found;
  logic [IW-1:0] vic_idx;
  always_comb begin
    int unsigned j;
    vic_found = 1'b0;
    vic_idx   = '0;
    for (int n = SLOTS - 1; n >= 0; n--) begin
      j = int'(mod_r_q) + n;
      if (j >= SLOTS) j = j - SLOTS;
      if (!pinned_q[j]) begin
        vic_found = 1'b1;
        vic_idx   = IW'(j);
      end
    end
  end

  // lowest dirty valid slot for flush
  logic [SLOTS-1:0] wb_mask, wb_rest;
  logic             wb_found;
  logic [IW-1:0]    wb_idx;
  assign wb_mask = valid_q & dirty_q;
  always_comb begin
    wb_found = 1'b0;
    wb_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (wb_mask[i]) begin
        wb_found = 1'b1;
        wb_idx   = IW'(i);
      end
    end
  end
  always_comb begin
    wb_rest = wb_mask;
    wb_rest[idx_q] = 1'b0;
  end

  // residue of nibble value v at nibble position k, elaboration-time constant
  function automatic int unsigned nib_res(int unsigned k, int unsigned v);
    int unsigned p;
    p = 1 % SLOTS;
    for (int unsigned m = 0; m < k; m++) p = (p * 16) % SLOTS;
    return (v * p) % SLOTS;
  endfunction

  // sector mod SLOTS: sum of per-nibble residues (below 8*SLOTS), then three
  // conditional subtracts; registered through mod_sum_q and then mod_r_q after sector_q
  // is loaded, well before the scan ends
  always_comb begin
    mod_sum_d = '0;
    for (int k = 0; k < SEC_W / 4; k++) begin
      for (int v = 1; v < 16; v++) begin
        if (sector_q[4*k +: 4] == 4'(v)) mod_sum_d = mod_sum_d + 9'(nib_res(k, v));
      end
    end
  end

  always_comb begin
    mod_red = mod_sum_q;
    if (mod_red >= 9'(4 * SLOTS)) mod_red = mod_red - 9'(4 * SLOTS);
    if (mod_red >= 9'(2 * SLOTS)) mod_red = mod_red - 9'(2 * SLOTS);
    if (mod_red >= 9'(SLOTS))     mod_red = mod_red - 9'(SLOTS);
  end

  logic [PIN_W-1:0] pin_inc, pin_dec;
  assign pin_inc = (rd_pin == PIN_MAX) ? PIN_MAX : rd_pin + 1'b1;
  assign pin_dec = (rd_pin == '0) ? '0 : rd_pin - 1'b1;

  // RAM port control
  always_comb begin
    ram_we = 1'b0;
    ram_wa = rd_idx_q;
    ram_wd = {pin_inc, rd_sec};
    ram_ra = addr_q;
    case (state_q)
      S_IDLE:  ram_ra = req_i.slot[IW-1:0];
      S_LOOK: begin
        ram_ra = addr_q;
        if (look_hit) ram_we = 1'b1;
      end
      S_MISS: begin
        ram_ra = vic_idx;
        if (inv_found) begin
          ram_we = 1'b1;
          ram_wa = inv_idx;
          ram_wd = {PIN_W'(1), sector_q};
        end
      end
      S_VICT: begin
        ram_we = 1'b1;
        ram_wa = idx_q;
        ram_wd = {PIN_W'(1), sector_q};
      end
      S_REL: begin
        ram_we = 1'b1;
        ram_wa = idx_q;
        ram_wd = {pin_dec, rd_sec};
      end
      S_FFIND: ram_ra = wb_idx;
      default: ram_we = 1'b0;
    endcase
  end

  scs_ram #(.WIDTH(RAM_W), .DEPTH(SLOTS)) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_wa),
    .wdata_i (ram_wd),
    .raddr_i (ram_ra),
    .rdata_o (ram_rd)
  );

  assign req_i.ready = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      valid_q    <= '0;
      dirty_q    <= '0;
      pinned_q   <= '0;
      mod_sum_q  <= '0;
      mod_r_q    <= '0;
      issue_q    <= 1'b0;
      rd_vld_q   <= 1'b0;
      flush_q    <= 1'b0;
      addr_q     <= '0;
      rd_idx_q   <= '0;
      idx_q      <= '0;
      sector_q   <= '0;
      dirty_in_q <= 1'b0;
      rsp_q      <= '0;
    end else begin
      rd_idx_q  <= ram_ra;
      mod_sum_q <= mod_sum_d;
      mod_r_q   <= mod_red[IW-1:0];
      case (state_q)
        S_IDLE: begin
          idx_q      <= req_i.slot[IW-1:0];
          dirty_in_q <= req_i.set_dirty;
          if (req_i.valid) begin
            case (func_e'(req_i.func))
              FUNC_ACQUIRE: begin
                sector_q  <= req_i.sector;
                addr_q    <= '0;
                issue_q   <= 1'b1;
                rd_vld_q  <= 1'b0;
                state_q   <= S_LOOK;
              end
              FUNC_RELEASE: begin
                if ({1'b0, req_i.slot} < (SLOT_W+1)'(SLOTS)) state_q <= S_REL;
              end
              FUNC_FLUSH: begin
                flush_q <= 1'b1;
                state_q <= S_FFIND;
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_LOOK: begin
          // pipelined scan: issue one read per cycle, compare the one issued the cycle before
          rd_vld_q <= issue_q;
          if (issue_q) begin
            addr_q <= addr_q + 1'b1;
            if (addr_q == IW'(SLOTS - 1)) issue_q <= 1'b0;
          end
          if (look_hit) begin
            pinned_q[rd_idx_q] <= 1'b1;
            rsp_q   <= '{slot_index: SLOT_W'(rd_idx_q), hit: 1'b1, write_back: 1'b0,
                         write_back_sector: '0, fill: 1'b0, all_pinned: 1'b0, last: 1'b1};
            state_q <= S_OUT;
          end else if (look_end) begin
            state_q <= S_MISS;
          end
        end
        S_MISS: begin
          if (inv_found) begin
            valid_q[inv_idx]  <= 1'b1;
            dirty_q[inv_idx]  <= 1'b0;
            pinned_q[inv_idx] <= 1'b1;
            rsp_q   <= '{slot_index: SLOT_W'(inv_idx), hit: 1'b0, write_back: 1'b0,
                         write_back_sector: '0, fill: 1'b1, all_pinned: 1'b0, last: 1'b1};
            state_q <= S_OUT;
          end else if (vic_found) begin
            idx_q   <= vic_idx;
            state_q <= S_VICT;
          end else begin
            rsp_q   <= '{slot_index: '0, hit: 1'b0, write_back: 1'b0,
                         write_back_sector: '0, fill: 1'b0, all_pinned: 1'b1, last: 1'b1};
            state_q <= S_OUT;
          end
        end
        S_VICT: begin
          // every slot is valid here; old sector comes back from the RAM
          valid_q[idx_q]  <= 1'b1;
          dirty_q[idx_q]  <= 1'b0;
          pinned_q[idx_q] <= 1'b1;
          rsp_q   <= '{slot_index: SLOT_W'(idx_q), hit: 1'b0, write_back: dirty_q[idx_q],
                       write_back_sector: dirty_q[idx_q] ? rd_sec : '0,
                       fill: 1'b1, all_pinned: 1'b0, last: 1'b1};
          state_q <= S_OUT;
        end
        S_REL: begin
          pinned_q[idx_q] <= (pin_dec != '0);
          if (dirty_in_q && valid_q[idx_q]) dirty_q[idx_q] <= 1'b1;
          state_q <= S_IDLE;
        end
        S_FFIND: begin
          if (wb_found) begin
            idx_q   <= wb_idx;
            state_q <= S_FDATA;
          end else begin
            valid_q <= valid_q & pinned_q;
            flush_q <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        S_FDATA: begin
          dirty_q[idx_q] <= 1'b0;
          rsp_q   <= '{slot_index: SLOT_W'(idx_q), hit: 1'b0, write_back: 1'b1,
                       write_back_sector: rd_sec, fill: 1'b0, all_pinned: 1'b0,
                       last: (wb_rest == '0)};
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (rsp_o.ready) state_q <= flush_q ? S_FFIND : S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o.valid             = (state_q == S_OUT);
  assign rsp_o.slot_index        = rsp_q.slot_index;
  assign rsp_o.hit               = rsp_q.hit;
  assign rsp_o.write_back        = rsp_q.write_back;
  assign rsp_o.write_back_sector = rsp_q.write_back_sector;
  assign rsp_o.fill              = rsp_q.fill;
  assign rsp_o.all_pinned        = rsp_q.all_pinned;
  assign rsp_o.last              = rsp_q.last;
endmodule
